// File: hw/rtl/rsuk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsuk_pkg
// Shared constants and types of the upper-key radix sorter.
// ----------------------------------------------------------------------------
package rsuk_pkg;

   localparam int KEY_W       = 64;
   localparam int BLOCK_DEPTH = 16384;
   localparam int IDX_W       = $clog2(BLOCK_DEPTH);
   localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);
   localparam int DIGIT_W     = 16;
   localparam int NUM_BUCKETS = 1 << DIGIT_W;
   localparam int LOW_SHIFT   = 32;
   localparam int HIGH_SHIFT  = 48;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CNT_RD,
      S_CNT_LOOK,
      S_CNT_WR,
      S_SCAN_RD,
      S_SCAN_WR,
      S_SCT_RD,
      S_SCT_LOOK,
      S_SCT_WR
   } sort_state_type;

   // one port pair of a key memory: a write and a read address
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [KEY_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage
`default_nettype wire

// File: hw/rtl/radix_sort_upper_key_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_sort_upper_key_unit
// Block sorter for 64-bit keys, stable on the upper 32 bits.
// ----------------------------------------------------------------------------
// Load: one word per cycle while req_stall is low, no result.
// Fetch: result via the pending flag; no request taken while one is pending.
// Sort: two passes of clear, count, scan and scatter over n keys, paced by the
//   read-modify-write of the bucket count memory; no word is taken meanwhile.
// Reset empties the block; key memories hold nothing valid until loaded.
module radix_sort_upper_key_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_kind,
   input  wire logic [rsuk_pkg::KEY_W-1:0] req_key_in,
   input  wire logic                      req_last_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [rsuk_pkg::KEY_W-1:0] rsp_key_out,
   output logic                           rsp_last_out,
   output logic                           rsp_empty_res
);
   import rsuk_pkg::*;

   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic [CNT_W-1:0] rptr_ff, rptr_in;
   logic             ready_ff, ready_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;
   logic             pend_empty_ff, pend_empty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_empty_ff, rsp_empty_in;

   logic             busy, start, accepted;
   logic [CNT_W-1:0] base, new_cnt;
   mem_req_type      srt_key_req, scr_req, key_req;
   logic [KEY_W-1:0] key_rdata, scr_rdata;

   assign req_stall = busy | pend_ff | (rsp_valid_ff & rsp_stall);
   assign accepted  = req_valid & ~req_stall;
   assign base      = ready_ff ? '0 : loaded_ff;
   assign new_cnt   = base + CNT_W'(1);

   always_comb begin
      loaded_in     = loaded_ff;
      rptr_in       = rptr_ff;
      ready_in      = ready_ff;
      pend_in       = 1'b0;
      pend_last_in  = pend_last_ff;
      pend_empty_in = pend_empty_ff;
      start         = 1'b0;
      key_req.we    = 1'b0;
      key_req.waddr = base[IDX_W-1:0];
      key_req.wdata = req_key_in;
      key_req.raddr = rptr_ff[IDX_W-1:0];
      if (accepted) begin
         if (req_kind == KIND_LOAD) begin
            key_req.we = 1'b1;
            loaded_in  = new_cnt;
            rptr_in    = '0;
            ready_in   = 1'b0;
            if (req_last_in || new_cnt == CNT_W'(BLOCK_DEPTH)) begin
               start    = 1'b1;
               ready_in = 1'b1;
            end
         end else begin
            pend_in       = 1'b1;
            pend_empty_in = ~ready_ff;
            pend_last_in  = ready_ff && (rptr_ff + CNT_W'(1) == loaded_ff);
            if (ready_ff) begin
               rptr_in = rptr_ff + CNT_W'(1);
               if (rptr_ff + CNT_W'(1) == loaded_ff) begin
                  // block fully read: release it
                  ready_in  = 1'b0;
                  loaded_in = '0;
                  rptr_in   = '0;
               end
            end
         end
      end
      if (busy) begin
         key_req = srt_key_req;
      end
   end

   always_comb begin
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = pend_empty_ff ? '0 : key_rdata;
         rsp_last_in  = pend_last_ff;
         rsp_empty_in = pend_empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         rptr_ff      <= '0;
         ready_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         rptr_ff      <= rptr_in;
         ready_ff     <= ready_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_last_ff  <= pend_last_in;
      pend_empty_ff <= pend_empty_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_last_out  = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

   rsuk_sorter u_sorter (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .count_in  (new_cnt),
      .key_rdata (key_rdata),
      .scr_rdata (scr_rdata),
      .busy      (busy),
      .key_req   (srt_key_req),
      .scr_req   (scr_req)
   );

   rsuk_ram #(.ADDR_W(IDX_W), .DATA_W(KEY_W)) u_key_ram (
      .clock (clock),
      .we    (key_req.we),
      .waddr (key_req.waddr),
      .wdata (key_req.wdata),
      .raddr (key_req.raddr),
      .rdata (key_rdata)
   );

   rsuk_ram #(.ADDR_W(IDX_W), .DATA_W(KEY_W)) u_scr_ram (
      .clock (clock),
      .we    (scr_req.we),
      .waddr (scr_req.waddr),
      .wdata (scr_req.wdata),
      .raddr (scr_req.raddr),
      .rdata (scr_rdata)
   );

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall) else $error("word taken while sorting");
   a_fetch_answers: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid) else $error("fetch produced no result");
   a_ready_nonempty: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> loaded_ff != '0) else $error("sorted block is empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(BLOCK_DEPTH)) else $error("block count overflow");
endmodule
`default_nettype wire

// File: hw/rtl/rsuk_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsuk_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module rsuk_ram #(
   parameter int ADDR_W = 14,
   parameter int DATA_W = 64
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [1 << ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: hw/rtl/rsuk_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsuk_sorter
// Two counting passes over 16-bit digits: clear, count, prefix scan, scatter.
// Owns the bucket count memory.
// ----------------------------------------------------------------------------
module rsuk_sorter (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rsuk_pkg::CNT_W-1:0] count_in,
   input  wire logic [rsuk_pkg::KEY_W-1:0] key_rdata,
   input  wire logic [rsuk_pkg::KEY_W-1:0] scr_rdata,
   output logic                           busy,
   output rsuk_pkg::mem_req_type          key_req,
   output rsuk_pkg::mem_req_type          scr_req
);
   import rsuk_pkg::*;

   localparam logic [DIGIT_W-1:0] LAST_BKT = DIGIT_W'(NUM_BUCKETS - 1);

   logic [CNT_W-1:0] cnt_mem [NUM_BUCKETS];
   logic [CNT_W-1:0] cnt_rdata_ff;

   sort_state_type   state_ff, state_in;
   logic             pass_ff, pass_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [DIGIT_W-1:0] bkt_ff, bkt_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic               cnt_we;
   logic [DIGIT_W-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]   cnt_wdata;
   logic [KEY_W-1:0]   src_rdata;
   logic [DIGIT_W-1:0] src_digit;
   logic [IDX_W-1:0]   src_raddr;
   logic               dst_we;
   logic [IDX_W-1:0]   dst_waddr;
   logic [CNT_W-1:0]   pos;

   assign src_rdata = pass_ff ? scr_rdata : key_rdata;
   assign src_digit = pass_ff ? src_rdata[HIGH_SHIFT +: DIGIT_W]
                              : src_rdata[LOW_SHIFT +: DIGIT_W];
   assign pos       = cnt_rdata_ff - CNT_W'(1);
   assign busy      = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pass_ff  <= pass_in;
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      acc_ff   <= acc_in;
      bkt_ff   <= bkt_in;
      digit_ff <= digit_in;
      key_ff   <= key_in;
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      acc_in    = acc_ff;
      bkt_in    = bkt_ff;
      digit_in  = digit_ff;
      key_in    = key_ff;
      cnt_we    = 1'b0;
      cnt_waddr = bkt_ff;
      cnt_wdata = '0;
      cnt_raddr = bkt_ff;
      src_raddr = idx_ff[IDX_W-1:0];
      dst_we    = 1'b0;
      dst_waddr = pos[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = count_in;
               pass_in  = 1'b0;
               bkt_in   = '0;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cnt_we = 1'b1;
            bkt_in = bkt_ff + DIGIT_W'(1);
            if (bkt_ff == LAST_BKT) begin
               idx_in   = '0;
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            state_in = S_CNT_LOOK;
         end
         S_CNT_LOOK: begin
            digit_in  = src_digit;
            cnt_raddr = src_digit;
            state_in  = S_CNT_WR;
         end
         S_CNT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = digit_ff;
            cnt_wdata = cnt_rdata_ff + CNT_W'(1);
            idx_in    = idx_ff + CNT_W'(1);
            if (idx_ff + CNT_W'(1) == n_ff) begin
               bkt_in   = '0;
               acc_in   = '0;
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_CNT_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_WR;
         end
         S_SCAN_WR: begin
            acc_in    = acc_ff + cnt_rdata_ff;
            cnt_we    = 1'b1;
            cnt_wdata = acc_in;
            bkt_in    = bkt_ff + DIGIT_W'(1);
            if (bkt_ff == LAST_BKT) begin
               idx_in   = n_ff;
               state_in = S_SCT_RD;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCT_RD: begin
            // scatter walks from the last key down to the first
            src_raddr = IDX_W'(idx_ff - CNT_W'(1));
            state_in  = S_SCT_LOOK;
         end
         S_SCT_LOOK: begin
            key_in    = src_rdata;
            digit_in  = src_digit;
            cnt_raddr = src_digit;
            state_in  = S_SCT_WR;
         end
         S_SCT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = digit_ff;
            cnt_wdata = pos;
            dst_we    = 1'b1;
            idx_in    = idx_ff - CNT_W'(1);
            if (idx_ff == CNT_W'(1)) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  bkt_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_SCT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // pass one: key store -> scratch, pass two: scratch -> key store
   always_comb begin
      key_req.we    = dst_we & pass_ff;
      key_req.waddr = dst_waddr;
      key_req.wdata = key_ff;
      key_req.raddr = src_raddr;
      scr_req.we    = dst_we & ~pass_ff;
      scr_req.waddr = dst_waddr;
      scr_req.wdata = key_ff;
      scr_req.raddr = src_raddr;
   end
endmodule
`default_nettype wire

// File: sim/radix_sort_upper_key_unit_test.sv
// ----------------------------------------------------------------------------
// radix_sort_upper_key_unit_test
// Self-checking bench for the upper-key radix sorter: loads blocks of keys,
// fetches the sorted words back and compares each one with a local model
// that sorts stably on bits 63..32 by two 16-bit counting passes.
// ----------------------------------------------------------------------------
module radix_sort_upper_key_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rsuk_pkg::*;

   localparam longint CYCLE_LIMIT = 12_000_000;

   typedef struct {
      logic [KEY_W-1:0] key;
      logic             last;
      logic             empty;
   } sorted_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_kind = KIND_LOAD;
   logic [KEY_W-1:0] req_key_in = '0;
   logic             req_last_in = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [KEY_W-1:0] rsp_key_out;
   logic             rsp_last_out;
   logic             rsp_empty_res;

   // local copy of the sorter's state
   logic [KEY_W-1:0] held_keys [BLOCK_DEPTH];
   logic [KEY_W-1:0] staged_keys [BLOCK_DEPTH];
   int unsigned      tally [NUM_BUCKETS];
   int unsigned      held_count = 0;
   int unsigned      fetch_ptr = 0;
   bit               block_sorted = 0;

   sorted_word_type  pending_words [$];
   int               mismatches = 0;
   int               stall_pct = 0;
   int               stall_left = 0;
   longint           cycles = 0;

   radix_sort_upper_key_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_key_in(req_key_in), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_key_out(rsp_key_out),
      .rsp_last_out(rsp_last_out), .rsp_empty_res(rsp_empty_res)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one stable counting pass; to_staged picks direction
   function automatic void digit_pass(int shift, bit to_staged);
      logic [KEY_W-1:0] k;
      int unsigned      d;
      for (int i = 0; i < NUM_BUCKETS; i++) tally[i] = 0;
      for (int i = 0; i < held_count; i++) begin
         k = to_staged ? held_keys[i] : staged_keys[i];
         d = 32'((k >> shift) & 64'hFFFF);
         tally[d]++;
      end
      for (int i = 1; i < NUM_BUCKETS; i++) tally[i] += tally[i-1];
      for (int i = held_count; i > 0; i--) begin
         k = to_staged ? held_keys[i-1] : staged_keys[i-1];
         d = 32'((k >> shift) & 64'hFFFF);
         tally[d]--;
         if (to_staged) staged_keys[tally[d]] = k;
         else held_keys[tally[d]] = k;
      end
   endfunction

   function automatic void predict_word(logic kind, logic [KEY_W-1:0] key, logic last);
      sorted_word_type w;
      if (kind == KIND_LOAD) begin
         if (block_sorted) begin
            block_sorted = 0;
            held_count = 0;
            fetch_ptr = 0;
         end
         if (held_count < BLOCK_DEPTH) begin
            held_keys[held_count] = key;
            held_count++;
         end
         if (last || held_count >= BLOCK_DEPTH) begin
            digit_pass(LOW_SHIFT, 1);
            digit_pass(HIGH_SHIFT, 0);
            block_sorted = 1;
            fetch_ptr = 0;
         end
         return;
      end
      if (!block_sorted || fetch_ptr >= held_count) begin
         w.key = '0; w.last = 0; w.empty = 1;
      end else begin
         w.key = held_keys[fetch_ptr];
         w.last = (fetch_ptr + 1 == held_count);
         w.empty = 0;
         fetch_ptr++;
         if (fetch_ptr >= held_count) begin
            block_sorted = 0;
            held_count = 0;
            fetch_ptr = 0;
         end
      end
      pending_words.push_back(w);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // output back-pressure in bursts, mostly short, now and then long
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= gap_len();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result checker
   always @(posedge clock) begin
      sorted_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word key=%h last=%b empty=%b",
                        rsp_key_out, rsp_last_out, rsp_empty_res);
         end else begin
            w = pending_words.pop_front();
            if (rsp_key_out !== w.key || rsp_last_out !== w.last ||
                rsp_empty_res !== w.empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp key=%h last=%b empty=%b got key=%h last=%b empty=%b",
                           w.key, w.last, w.empty, rsp_key_out, rsp_last_out, rsp_empty_res);
            end
         end
      end
   end

   task automatic send_word(logic kind, logic [KEY_W-1:0] key, logic last, bit idle = 1);
      int g;
      g = idle ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key_in <= key;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(kind, key, last);
   endtask

   task automatic send_fetch();
      send_word(KIND_FETCH, {$urandom, $urandom}, 1'($urandom_range(1)));
   endtask

   function automatic logic [KEY_W-1:0] tie_key();
      // narrow upper halves so ties and shared digits are frequent
      logic [15:0] hi, lo;
      hi = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      lo = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
      return {hi, lo, 32'($urandom)};
   endfunction

   task automatic test_fetch_when_empty();
      stall_pct = 0;
      repeat (3) send_fetch();
   endtask

   task automatic test_single_key();
      send_word(KIND_LOAD, '1, 1'b1);
      send_fetch();
      send_fetch();   // past the end
   endtask

   task automatic test_extremes_and_ties();
      logic [KEY_W-1:0] keys [10];
      stall_pct = 30;
      keys = '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_0000,
               64'h1234_5678_0000_0001, 64'h1234_5678_0000_0000, 64'h0000_FFFF_AAAA_AAAA,
               64'hFFFF_0000_5555_5555, 64'h1234_5678_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h0001_0000_0000_0000};
      foreach (keys[i]) begin
         send_word(KIND_LOAD, keys[i], i == 9);
         if (i == 4) send_fetch();   // still loading
      end
      repeat (11) send_fetch();
   endtask

   task automatic test_partial_readout();
      stall_pct = 50;
      for (int i = 0; i < 64; i++) begin
         send_word(KIND_LOAD, ($urandom_range(7) == 0) ? {$urandom, $urandom} : tie_key(),
                   i == 63, i % 32 < 8);
         if (i == 10 || i == 40) send_fetch();
      end
      repeat (30) send_fetch();   // readout left unfinished on purpose
   endtask

   task automatic test_random_blocks();
      int n;
      for (int b = 0; b < 2; b++) begin
         stall_pct = b == 0 ? 40 : 10;
         n = $urandom_range(420, 320);
         // first load here drops any unread words of the previous block
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) send_fetch();
            send_word(KIND_LOAD, ($urandom_range(1) == 1) ? {$urandom, $urandom} : tie_key(),
                      i == n - 1, i % 100 < 60);
         end
         n = (b == 0) ? n - $urandom_range(40, 5) : n + $urandom_range(8, 2);
         for (int i = 0; i < n; i++) send_word(KIND_FETCH, {$urandom, $urandom},
                                               1'($urandom_range(1)), i % 128 < 90);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fetch_when_empty();
      test_single_key();
      test_extremes_and_ties();
      test_partial_readout();
      test_random_blocks();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
